// File: design/bit_field_buffer_access_defines.svh
// Assertion macros for the bit field buffer access block.
`ifndef BIT_FIELD_BUFFER_ACCESS_DEFINES_SVH
`define BIT_FIELD_BUFFER_ACCESS_DEFINES_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT_CLK(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define BFA_ASSERT(lbl, prop, msg) `BFA_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define BFA_ASSERT_CLK(lbl, ck, rn, prop, msg)
`define BFA_ASSERT(lbl, prop, msg)
`endif
`endif

// File: design/bfa_pkg.sv
// Package: field widths, request kinds, status codes and sequencer states.
`default_nettype none
package bfa_pkg;

	localparam int unsigned KIND_W = 3;
	localparam int unsigned POS_W  = 14;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned OFF_W  = 6;

	localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

	localparam logic [KIND_W-1:0] KIND_GET_U  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_GET_S  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GET_SM = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SET    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SET_SM = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADLEN = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_CALC,
		ST_WR0,
		ST_WR1,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: design/bfa_req_if.sv
// Request channel: kind, bit position, length and data of one access.
`default_nettype none
interface bfa_req_if import bfa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [POS_W-1:0]  bit_pos;
	logic [LEN_W-1:0]  field_len;
	logic [DATA_W-1:0] data;

	modport source (output valid, kind, bit_pos, field_len, data, input ready);
	modport sink   (input valid, kind, bit_pos, field_len, data, output ready);
endinterface
`default_nettype wire

// File: design/bfa_rsp_if.sv
// Response channel: extracted value and status of one access.
`default_nettype none
interface bfa_rsp_if import bfa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] value;
	logic [STAT_W-1:0] status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

// File: design/bfa_mem.sv
// Message buffer store: 64-bit words, one write and one registered read port.
`default_nettype none
module bfa_mem import bfa_pkg::*; #(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: design/bit_field_buffer_access.sv
// Top level: MSB-first bit field get/set on a word-organised message buffer.
//
//  channel | dir | payload                          | handshake
//  req     | in  | kind, bit_pos, field_len, data   | valid/ready
//  rsp     | out | value, status                    | valid/ready
//
// One word at a time. A get steps through RD0, RD1 and CALC to DONE, where the result register
// is loaded; a set adds WR0 (field inside one memory word) or WR0 and WR1 (field across two).
// A rejected word goes from IDLE straight to DONE. Two serial reads through the one read port,
// then up to two write-backs, make up these steps; a new word waits until DONE is left.
// After reset a clearing pass zeroes the buffer; no word is taken meanwhile. A new word is taken
// while a result still waits.
`default_nettype none
`include "bit_field_buffer_access_defines.svh"
module bit_field_buffer_access import bfa_pkg::*; #(
	parameter int unsigned BUF_BYTES = 2048
) (
	input wire logic   clk,
	input wire logic   arst_n,
	bfa_req_if.sink    req,
	bfa_rsp_if.source  rsp
);

	localparam int unsigned WORDS    = (BUF_BYTES + 7) / 8;
	localparam int unsigned AW       = $clog2(WORDS);
	localparam int unsigned BUF_BITS = BUF_BYTES * 8;

	state_t state_q, state_d;

	logic [AW-1:0] clr_q;

	// accept-time decode
	logic              is_sm;
	logic              bad_len;
	logic              past_end;
	logic [31:0]       end_bits;
	logic [STAT_W-1:0] stat_d;
	logic [LEN_W-1:0]  lsh;
	logic              neg;
	logic [DATA_W-1:0] mag;
	logic [DATA_W-1:0] sm_sh;
	logic [DATA_W-1:0] aligned_d;
	logic [DATA_W-1:0] mask_d;
	logic [7:0]        end_off;

	// request registers
	logic [KIND_W-1:0] kind_q;
	logic [OFF_W-1:0]  off_q;
	logic [LEN_W-1:0]  len_q;
	logic [DATA_W-1:0] aligned_q;
	logic [DATA_W-1:0] mask_q;
	logic              span_q;
	logic [STAT_W-1:0] stat_q;
	logic [AW-1:0]     a0_q;
	logic [AW-1:0]     a1_q;

	// read/modify
	logic [DATA_W-1:0]   w0_q;
	logic [DATA_W-1:0]   w1_sel;
	logic [2*DATA_W-1:0] window;
	logic [2*DATA_W-1:0] win_sh;
	logic [2*DATA_W-1:0] mask128;
	logic [2*DATA_W-1:0] ins128;
	logic [2*DATA_W-1:0] merged;
	logic [DATA_W-1:0]   top_q;
	logic [DATA_W-1:0]   m0_q;
	logic [DATA_W-1:0]   m1_q;

	// result
	logic [LEN_W-1:0]         rsh;
	logic [DATA_W-1:0]        uval;
	logic signed [DATA_W-1:0] top_s;
	logic [DATA_W-1:0]        sval;
	logic [DATA_W-1:0]        smag;
	logic [DATA_W-1:0]        smval;
	logic [DATA_W-1:0]        value_d;
	logic                     out_free;
	logic                     out_valid_q;
	logic [DATA_W-1:0]        out_value_q;
	logic [STAT_W-1:0]        out_status_q;

	// sequencer outputs
	logic              accept;
	logic              ld_w0;
	logic              ld_calc;
	logic              ld_out;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	bfa_mem #(.DEPTH(WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// ---- request decode ----
	always_comb begin
		is_sm    = (req.kind == KIND_GET_SM) || (req.kind == KIND_SET_SM);
		bad_len  = (req.kind > KIND_SET_SM) || (req.field_len == '0) ||
			(is_sm && (req.field_len == 7'd1)) || (req.field_len > MAX_LEN);
		end_bits = 32'(req.bit_pos) + 32'(req.field_len);
		past_end = end_bits > 32'(BUF_BITS);
		if (bad_len) begin
			stat_d = STAT_BADLEN;
		end else if (past_end) begin
			stat_d = STAT_RANGE;
		end else begin
			stat_d = STAT_OK;
		end
		lsh   = MAX_LEN - req.field_len;
		neg   = req.data[DATA_W-1];
		mag   = neg ? (DATA_W'(0) - req.data) : req.data;
		sm_sh = mag << lsh;
		if (req.kind == KIND_SET_SM) begin
			aligned_d = {neg, sm_sh[DATA_W-2:0]};
		end else begin
			aligned_d = req.data << lsh;
		end
		mask_d  = ~({DATA_W{1'b1}} >> req.field_len);
		end_off = 8'(req.bit_pos[OFF_W-1:0]) + 8'(req.field_len);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			off_q     <= req.bit_pos[OFF_W-1:0];
			len_q     <= req.field_len;
			aligned_q <= aligned_d;
			mask_q    <= mask_d;
			span_q    <= end_off > 8'(MAX_LEN);
			stat_q    <= stat_d;
			a0_q      <= AW'(req.bit_pos >> OFF_W);
			a1_q      <= AW'(req.bit_pos >> OFF_W) + AW'(1);
		end
	end

	// ---- read-modify ----
	always_comb begin
		w1_sel  = span_q ? mem_rdata : '0;
		window  = {w0_q, w1_sel};
		win_sh  = window << off_q;
		mask128 = {mask_q, {DATA_W{1'b0}}} >> off_q;
		ins128  = {aligned_q, {DATA_W{1'b0}}} >> off_q;
		merged  = (window & ~mask128) | ins128;
	end

	always_ff @(posedge clk) begin
		if (ld_w0) begin
			w0_q <= mem_rdata;
		end
		if (ld_calc) begin
			top_q <= win_sh[2*DATA_W-1:DATA_W];
			m0_q  <= merged[2*DATA_W-1:DATA_W];
			m1_q  <= merged[DATA_W-1:0];
		end
	end

	// ---- result ----
	always_comb begin
		rsh   = MAX_LEN - len_q;
		top_s = top_q;
		uval  = top_q >> rsh;
		sval  = top_s >>> rsh;
		smag  = {top_q[DATA_W-2:0], 1'b0} >> (rsh + 7'd1);
		smval = top_q[DATA_W-1] ? (DATA_W'(0) - smag) : smag;
		value_d = '0;
		if (stat_q == STAT_OK) begin
			case (kind_q)
				KIND_GET_U:  value_d = uval;
				KIND_GET_S:  value_d = sval;
				KIND_GET_SM: value_d = smval;
				default:     value_d = '0;
			endcase
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_value_q  <= value_d;
			out_status_q <= stat_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (stat_d == STAT_OK) ? ST_RD0 : ST_DONE;
				end
			end
			ST_RD0: state_d = ST_RD1;
			ST_RD1: state_d = ST_CALC;
			ST_CALC: begin
				if (kind_q == KIND_SET || kind_q == KIND_SET_SM) begin
					state_d = ST_WR0;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_WR0: state_d = span_q ? ST_WR1 : ST_DONE;
			ST_WR1: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ld_w0     = 1'b0;
		ld_calc   = 1'b0;
		ld_out    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = a0_q;
		mem_wdata = m0_q;
		mem_raddr = a0_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: req.ready = 1'b1;
			ST_RD0:  mem_raddr = a0_q;
			ST_RD1: begin
				mem_raddr = a1_q;
				ld_w0     = 1'b1;
			end
			ST_CALC: ld_calc = 1'b1;
			ST_WR0:  mem_we = 1'b1;
			ST_WR1: begin
				mem_we    = 1'b1;
				mem_waddr = a1_q;
				mem_wdata = m1_q;
			end
			ST_DONE: ld_out = out_free;
			default: req.ready = 1'b0;
		endcase
	end

	assign accept = req.valid && req.ready;

	// ---- checks ----
	`BFA_ASSERT(a_wr1_span, (state_q == ST_WR1) |-> span_q, "second word written for one-word field")
	`BFA_ASSERT(a_calc_next, (state_q == ST_CALC) |=> (state_q == ST_WR0 || state_q == ST_DONE), "bad step after modify")
	`BFA_ASSERT(a_out_from_done, $rose(rsp.valid) |-> $past(state_q == ST_DONE), "result loaded outside done")
	`BFA_ASSERT(a_err_skip, (accept && stat_d != STAT_OK) |=> (state_q == ST_DONE), "rejected word touched the buffer")
	`BFA_ASSERT(a_we_ok, mem_we |-> (state_q == ST_CLEAR || stat_q == STAT_OK), "write for a rejected word")

endmodule
`default_nettype wire
